/* src/p2ag_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the glyph lookup for the pixel-to-glyph block.
package p2ag_pkg;

	// configuration register widths and indexes
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 12;
	localparam int WIN_REG_W  = 5;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

	localparam logic [IMG_W_W-1:0]   RESET_IMAGE_WIDTH  = 11'd120;
	localparam logic [IMG_H_W-1:0]   RESET_IMAGE_HEIGHT = 12'd240;
	localparam logic [WIN_REG_W-1:0] RESET_WINDOW_SIZE  = 5'd1;

	localparam logic [IMG_H_W-1:0] MAX_HEIGHT = 12'd2048;

	// pixel and luma
	localparam int PIX_W  = 8;
	localparam int LUMA_W = 24;
	localparam logic [LUMA_W-1:0] LUMA_R = 24'd19595;
	localparam logic [LUMA_W-1:0] LUMA_G = 24'd38470;
	localparam logic [LUMA_W-1:0] LUMA_B = 24'd7471;

	// counters and sums
	localparam int ROW_W   = 11;
	localparam int PROW_W  = 10;
	localparam int OUT_H_W = 11;
	localparam int SUM_W   = 16;

	// glyph mapping
	localparam int GLYPH_W     = 7;
	localparam int GLYPH_COUNT = 15;
	localparam int GLYPH_STEP  = 18;
	localparam int GIDX_W      = 4;

	// dark to light: M N H Q $ O C ? 7 > ! : - ; .
	localparam logic [GLYPH_W-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
		7'h4D, 7'h4E, 7'h48, 7'h51, 7'h24, 7'h4F, 7'h43, 7'h3F,
		7'h37, 7'h3E, 7'h21, 7'h3A, 7'h2D, 7'h3B, 7'h2E
	};

	// operations of the shared divider
	typedef enum logic [2:0] {
		OP_COL,
		OP_ROW,
		OP_WID,
		OP_HGT,
		OP_AVG
	} div_op_t;

	typedef struct packed {
		logic    take;
		logic    luma_en;
		logic    line_write;
		logic    div_start;
		div_op_t div_op;
		logic    sum_write;
		logic    emit;
		logic    advance;
	} cmd_t;

	typedef struct packed {
		logic row_odd;
		logic div_done;
		logic window_done;
		logic glyph_ok;
		logic out_free;
	} status_t;

	// index = min(avg / 18, 14), counted as thresholds passed
	function automatic logic [GLYPH_W-1:0] glyph_code(input logic [SUM_W-1:0] avg);
		logic [GIDX_W-1:0] idx;
		idx = '0;
		for (int n = 1; n < GLYPH_COUNT; n++) begin
			if (avg >= SUM_W'(GLYPH_STEP * n)) begin
				idx = idx + GIDX_W'(1);
			end
		end
		return GLYPH_TABLE[idx];
	endfunction

endpackage

/* src/pixel_to_ascii_glyph.sv */
`timescale 1ns / 1ps
// Top level: RGB pixel stream in, ASCII-art glyph stream out.
//
// Usage:
//  - Pixels enter in raster order on in_valid/in_ready with red, green, blue.
//    Each word is one pixel; rows are image_width pixels, frames image_height rows.
//  - Glyphs leave on out_valid/out_ready: glyph (ASCII code), end_of_row on the
//    last glyph of an output row, end_of_frame on the last glyph of the frame.
//  - Config: cfg_write_en with cfg_index 0 = image_width, 1 = image_height,
//    2 = window_size; write only while no pixel is in flight.
//  - One pixel is processed at a time; its processing time is set by the shared
//    one-bit-per-cycle divider: even rows store luma with no division, odd rows
//    run the column and row divisions, and the last pixel of a window runs three
//    more divisions (width, height, average) and the emit.
//  - A glyph enters the output register on the emit that follows its last division.
//  - The output register decouples the sides: the next pixel is accepted while a
//    glyph waits; a stall only holds the block when a second glyph is ready.
//  - Reset (arst_n low) clears counters, the controller and out_valid and loads
//    width 120, height 240, window 1. The line store and window sums are not
//    cleared; they are always written before they are read within a frame.
module pixel_to_ascii_glyph #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [p2ag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [p2ag_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [p2ag_pkg::PIX_W-1:0]        red,
	input  logic [p2ag_pkg::PIX_W-1:0]        green,
	input  logic [p2ag_pkg::PIX_W-1:0]        blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [p2ag_pkg::GLYPH_W-1:0]      glyph,
	output logic                              end_of_row,
	output logic                              end_of_frame
);
	import p2ag_pkg::*;

	cmd_t    cmd;
	status_t status;

	// controller: one state machine, registered commands
	p2ag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: luma, line store, window sums, divider, output register
	p2ag_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.glyph        (glyph),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	// ready only while the controller waits for a pixel
	assign in_ready = cmd.take;

endmodule

/* src/p2ag_div.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
module p2ag_div #(
	parameter int DW  = 16,
	parameter int DVW = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [DW-1:0]  quotient,
	output logic [DVW-1:0] remainder
);
	localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

	logic [DW-1:0]  quo_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [DVW:0] trial;
	logic         fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVW'(trial - {1'b0, div_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DVW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

endmodule

/* src/p2ag_datapath.sv */
`timescale 1ns / 1ps
// Datapath: config registers, luma, line store, window sums, divider and output register.
module p2ag_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [p2ag_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [p2ag_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	input  logic [p2ag_pkg::PIX_W-1:0]           red,
	input  logic [p2ag_pkg::PIX_W-1:0]           green,
	input  logic [p2ag_pkg::PIX_W-1:0]           blue,
	input  p2ag_pkg::cmd_t                       cmd,
	output p2ag_pkg::status_t                    status,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [p2ag_pkg::GLYPH_W-1:0]         glyph,
	output logic                                 end_of_row,
	output logic                                 end_of_frame
);
	import p2ag_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int WINW = $clog2(MAX_WINDOW + 1);
	localparam int SQW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int DW   = (WW > SUM_W) ? WW : SUM_W;

	// configuration
	logic [IMG_W_W-1:0]   image_width_q;
	logic [IMG_H_W-1:0]   image_height_q;
	logic [WIN_REG_W-1:0] window_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RESET_IMAGE_WIDTH;
			image_height_q <= RESET_IMAGE_HEIGHT;
			window_size_q  <= RESET_WINDOW_SIZE;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_W-1:0];
				REG_WINDOW_SIZE:  window_size_q  <= cfg_data[WIN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// registers in clamped form
	logic [WW-1:0]      w_c;
	logic [IMG_H_W-1:0] h_c;
	logic [WINW-1:0]    win_c;
	logic [SQW-1:0]     win_sq;

	always_comb begin
		if (image_width_q == '0)
			w_c = WW'(1);
		else if (image_width_q > MAX_WIDTH)
			w_c = WW'(MAX_WIDTH);
		else
			w_c = WW'(image_width_q);

		if (image_height_q == '0)
			h_c = IMG_H_W'(1);
		else if (image_height_q > MAX_HEIGHT)
			h_c = MAX_HEIGHT;
		else
			h_c = image_height_q;

		if (window_size_q == '0)
			win_c = WINW'(1);
		else if (window_size_q > MAX_WINDOW)
			win_c = WINW'(MAX_WINDOW);
		else
			win_c = WINW'(window_size_q);
	end

	assign win_sq = SQW'(win_c) * SQW'(win_c);

	// position counters and captured pixel
	logic [CW-1:0]    col_cnt_q;
	logic [ROW_W-1:0] row_cnt_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] red_q, green_q, blue_q;

	always_ff @(posedge clk) begin
		if (cmd.take && in_valid) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
			col_q   <= col_cnt_q;
			row_q   <= row_cnt_q;
		end
	end

	logic last_col, last_row;
	assign last_col = (WW'(col_q) + WW'(1)) >= w_c;
	assign last_row = (IMG_H_W'(row_q) + IMG_H_W'(1)) >= h_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (cmd.advance) begin
			if (last_col) begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_cnt_q <= col_q + CW'(1);
			end
		end
	end

	// luma, truncated fixed point
	logic [LUMA_W-1:0] luma_sum;
	logic [PIX_W-1:0]  luma_q;

	assign luma_sum = LUMA_R * LUMA_W'(red_q) + LUMA_G * LUMA_W'(green_q)
		+ LUMA_B * LUMA_W'(blue_q);

	always_ff @(posedge clk) begin
		if (cmd.luma_en)
			luma_q <= luma_sum[LUMA_W-1:LUMA_W-PIX_W];
	end

	// line store of the upper row
	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0] upper_q;

	always_ff @(posedge clk) begin
		if (cmd.line_write)
			line_mem[col_q] <= luma_q;
		upper_q <= line_mem[col_q];
	end

	logic [PIX_W:0]   pair_sum;
	logic [PIX_W-1:0] pair;
	assign pair_sum = {1'b0, upper_q} + {1'b0, luma_q};
	assign pair     = pair_sum[PIX_W:1];

	// shared divider
	logic [DW-1:0]  dividend;
	logic [SQW-1:0] divisor;
	logic           div_done;
	logic [DW-1:0]  quotient;
	logic [SQW-1:0] remainder;

	logic [CW-1:0]      wcol_q;
	logic [WINW-1:0]    j_q;
	logic [PROW_W-1:0]  wrow_q;
	logic [WINW-1:0]    k_q;
	logic [WW-1:0]      out_w_q;
	logic [OUT_H_W-1:0] out_h_q;
	logic [SUM_W-1:0]   new_sum_q;
	logic [SUM_W-1:0]   avg_q;

	always_comb begin
		unique case (cmd.div_op)
			OP_COL: begin
				dividend = DW'(col_q);
				divisor  = SQW'(win_c);
			end
			OP_ROW: begin
				dividend = DW'(row_q[ROW_W-1:1]);
				divisor  = SQW'(win_c);
			end
			OP_WID: begin
				dividend = DW'(w_c);
				divisor  = SQW'(win_c);
			end
			OP_HGT: begin
				dividend = DW'(h_c[IMG_H_W-1:1]);
				divisor  = SQW'(win_c);
			end
			OP_AVG: begin
				dividend = DW'(new_sum_q);
				divisor  = win_sq;
			end
			default: begin
				dividend = '0;
				divisor  = SQW'(1);
			end
		endcase
	end

	p2ag_div #(
		.DW  (DW),
		.DVW (SQW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_op)
				OP_COL: begin
					wcol_q <= quotient[CW-1:0];
					j_q    <= remainder[WINW-1:0];
				end
				OP_ROW: begin
					wrow_q <= quotient[PROW_W-1:0];
					k_q    <= remainder[WINW-1:0];
				end
				OP_WID: out_w_q <= quotient[WW-1:0];
				OP_HGT: out_h_q <= quotient[OUT_H_W-1:0];
				OP_AVG: avg_q   <= quotient[SUM_W-1:0];
				default: ;
			endcase
		end
	end

	// window sums, one per window column
	logic [SUM_W-1:0] sum_mem [MAX_WIDTH];
	logic [SUM_W-1:0] sum_rd_q;
	logic [SUM_W-1:0] new_sum;

	assign new_sum = ((k_q == '0) && (j_q == '0)) ? SUM_W'(pair)
		: sum_rd_q + SUM_W'(pair);

	always_ff @(posedge clk) begin
		if (cmd.sum_write) begin
			sum_mem[wcol_q] <= new_sum;
			new_sum_q       <= new_sum;
		end
		sum_rd_q <= sum_mem[wcol_q];
	end

	// window position checks
	logic window_done, glyph_ok, eor, eof, out_free, load;

	assign window_done = (WINW'(k_q + WINW'(1)) == win_c) && (WINW'(j_q + WINW'(1)) == win_c);
	assign glyph_ok    = (WW'(wcol_q) < out_w_q) && ({1'b0, wrow_q} < out_h_q);
	assign eor         = (WW'(wcol_q) + WW'(1)) == out_w_q;
	assign eof         = eor && (({1'b0, wrow_q} + OUT_H_W'(1)) == out_h_q);

	// output register
	logic               out_valid_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic               eor_q, eof_q;

	assign out_free = !out_valid_q || out_ready;
	assign load     = cmd.emit && glyph_ok && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			glyph_q <= glyph_code(avg_q);
			eor_q   <= eor;
			eof_q   <= eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign glyph        = glyph_q;
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

	assign status.row_odd     = row_q[0];
	assign status.div_done    = div_done;
	assign status.window_done = window_done;
	assign status.glyph_ok    = glyph_ok;
	assign status.out_free    = out_free;

	a_line_even_rows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.line_write |-> !row_q[0])
		else $error("line store written on an odd row");

	a_sum_odd_rows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_write |-> row_q[0])
		else $error("window sum written on an even row");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("glyph load did not raise out_valid");

endmodule

/* src/p2ag_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences one pixel at a time through luma, divider and window sums.
module p2ag_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  p2ag_pkg::status_t   status,
	output p2ag_pkg::cmd_t      cmd
);
	import p2ag_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LUMA,
		S_STORE,
		S_DIV,
		S_SUM_READ,
		S_SUM_WRITE,
		S_EMIT,
		S_DONE
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			cmd_q.take   <= 1'b1;
			cmd_q.div_op <= OP_COL;
		end else begin
			cmd_q.luma_en    <= 1'b0;
			cmd_q.line_write <= 1'b0;
			cmd_q.div_start  <= 1'b0;
			cmd_q.sum_write  <= 1'b0;
			cmd_q.emit       <= 1'b0;
			cmd_q.advance    <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q       <= S_LUMA;
						cmd_q.take    <= 1'b0;
						cmd_q.luma_en <= 1'b1;
					end
				end
				S_LUMA: begin
					if (status.row_odd) begin
						state_q         <= S_DIV;
						cmd_q.div_op    <= OP_COL;
						cmd_q.div_start <= 1'b1;
					end else begin
						state_q          <= S_STORE;
						cmd_q.line_write <= 1'b1;
					end
				end
				S_STORE: begin
					state_q       <= S_DONE;
					cmd_q.advance <= 1'b1;
				end
				S_DIV: begin
					if (status.div_done) begin
						unique case (cmd_q.div_op)
							OP_COL: begin
								cmd_q.div_op    <= OP_ROW;
								cmd_q.div_start <= 1'b1;
							end
							OP_ROW: state_q <= S_SUM_READ;
							OP_WID: begin
								cmd_q.div_op    <= OP_HGT;
								cmd_q.div_start <= 1'b1;
							end
							OP_HGT: begin
								cmd_q.div_op    <= OP_AVG;
								cmd_q.div_start <= 1'b1;
							end
							OP_AVG: begin
								state_q    <= S_EMIT;
								cmd_q.emit <= 1'b1;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SUM_READ: begin
					state_q         <= S_SUM_WRITE;
					cmd_q.sum_write <= 1'b1;
				end
				S_SUM_WRITE: begin
					if (status.window_done) begin
						state_q         <= S_DIV;
						cmd_q.div_op    <= OP_WID;
						cmd_q.div_start <= 1'b1;
					end else begin
						state_q       <= S_DONE;
						cmd_q.advance <= 1'b1;
					end
				end
				S_EMIT: begin
					if (!status.glyph_ok || status.out_free) begin
						state_q       <= S_DONE;
						cmd_q.advance <= 1'b1;
					end else begin
						cmd_q.emit <= 1'b1;
					end
				end
				S_DONE: begin
					state_q    <= S_IDLE;
					cmd_q.take <= 1'b1;
				end
				default: begin
					state_q    <= S_IDLE;
					cmd_q.take <= 1'b1;
				end
			endcase
		end
	end

	assign cmd = cmd_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pixel_to_ascii_glyph: random raster frames against a glyph predictor.
module tb_top;
	import p2ag_pkg::*;

	// run length guard: about 2k pixels, each at the worst-case pixel time plus the
	// largest sender gap and receiver stall, taken more than ten times over
	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int SETTLE_CYCLES = 150;    // lets the block finish a last word that made no glyph
	localparam int DRAIN_LIMIT   = 20_000;
	localparam int LONG_HOLD     = 1200;
	localparam int RANDOM_WORDS  = 1150;

	// dark to light, first character in the top byte
	localparam logic [8*GLYPH_COUNT-1:0] GLYPH_RAMP = "MNHQ$OC?7>!:-;.";

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] code;
		logic               row_end;
		logic               frame_end;
	} glyph_word_t;

	// how a side spaces its handshakes over a stretch of words
	typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} pace_t;
	// pixel content of one frame
	typedef enum int {TONE_NOISE, TONE_SATURATED, TONE_TILES} tone_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     red          = '0;
	logic [PIX_W-1:0]     green        = '0;
	logic [PIX_W-1:0]     blue         = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [GLYPH_W-1:0]   glyph;
	logic                 end_of_row;
	logic                 end_of_frame;

	pixel_to_ascii_glyph i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.glyph       (glyph),
		.end_of_row  (end_of_row),
		.end_of_frame(end_of_frame)
	);

	// pixels waiting for the driver, glyphs waiting for the block
	rgb_t        pixel_queue[$];
	glyph_word_t expected_glyphs[$];
	int          mismatch_count = 0;

	// predictor copy of the registers (raw, as written) and of the block state
	logic [IMG_W_W-1:0]   width_reg  = RESET_IMAGE_WIDTH;
	logic [IMG_H_W-1:0]   height_reg = RESET_IMAGE_HEIGHT;
	logic [WIN_REG_W-1:0] window_reg = RESET_WINDOW_SIZE;
	int unsigned          col_count  = 0;
	int unsigned          row_count  = 0;
	logic [7:0]           upper_luma [1024];
	int unsigned          window_sum [1024];

	// handshake bookkeeping, sampled at the rising edge
	logic  pix_taken   = 1'b0;
	logic  glyph_taken = 1'b0;
	pace_t tx_pace = PACE_FULL, rx_pace = PACE_FULL;
	int    tx_left = 0, rx_left = 0;
	int    tx_gap = 0, rx_stall = 0;
	bit    hold_go = 1'b0;    // raised once by the stimulus; receiver then stalls
	bit    hold_done = 1'b0;
	int    tile_shade [1024];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Follows one accepted pixel through luma, pairing and window accumulation;
	// queues a glyph word when the pixel closes a whole window.
	task automatic predict_glyph(input rgb_t px);
		int unsigned w, h, win, luma, col, row, pair, prow;
		int unsigned k, j, wcol, wrow, out_w, out_h, idx;
		glyph_word_t word;
		w     = clamp_to(32'(width_reg), 1, 1024);
		h     = clamp_to(32'(height_reg), 1, 2048);
		win   = clamp_to(32'(window_reg), 1, 16);
		luma  = (19595 * px.red + 38470 * px.green + 7471 * px.blue) >> 16;
		col   = col_count;
		row   = row_count;
		if (!row[0]) begin
			upper_luma[col] = luma[7:0];
		end else begin
			pair  = (upper_luma[col] + luma) >> 1;
			prow  = row >> 1;
			k     = prow % win;
			j     = col % win;
			wcol  = col / win;
			wrow  = prow / win;
			out_w = w / win;
			out_h = (h >> 1) / win;
			if (k == 0 && j == 0) begin
				window_sum[wcol] = pair;
			end else begin
				window_sum[wcol] = window_sum[wcol] + pair;
			end
			if (k + 1 == win && j + 1 == win && wcol < out_w && wrow < out_h) begin
				idx = (window_sum[wcol] / (win * win)) / 18;
				if (idx > 14) begin
					idx = 14;
				end
				word.code      = GLYPH_RAMP[8 * (GLYPH_COUNT - 1 - idx) +: GLYPH_W];
				word.row_end   = (wcol + 1 == out_w);
				word.frame_end = word.row_end && (wrow + 1 == out_h);
				expected_glyphs.push_back(word);
			end
		end
		if (col + 1 >= w) begin
			col_count = 0;
			row_count = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col_count = col + 1;
		end
	endtask

	// Per-word wait for either side; the pace changes every few dozen words
	// so that runs with no idling alternate with heavy ones.
	task automatic draw_wait(inout pace_t pace, inout int left, output int cycles);
		if (left == 0) begin
			pace = pace_t'($urandom_range(0, 2));
			left = $urandom_range(16, 64);
		end
		left--;
		case (pace)
			PACE_FULL:   cycles = 0;
			PACE_RANDOM: cycles = $urandom_range(0, 19);
			default:     cycles = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 19)
			                                                  : $urandom_range(0, 2);
		endcase
	endtask

	// ---------------------------------------------------------------- input side
	// acceptance is seen at the rising edge; the predictor runs right there
	always @(posedge clk) begin
		pix_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			predict_glyph('{red, green, blue});
		end
	end

	// driver: valid held with a stable word until taken, then a gap, then the next
	always @(negedge clk) begin : pixel_driver
		rgb_t px;
		if (arst_n) begin
			if (in_valid && pix_taken) begin
				draw_wait(tx_pace, tx_left, tx_gap);
			end
			if (!in_valid || pix_taken) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pixel_queue.size() != 0) begin
					px = pixel_queue.pop_front();
					red      <= px.red;
					green    <= px.green;
					blue     <= px.blue;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------- output side
	// receiver: a random wait, possibly none, after each glyph; one long hold-off so the block backs up
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_go && !hold_done) begin
				rx_stall  = LONG_HOLD;
				hold_done = 1'b1;
			end else if (out_ready && glyph_taken) begin
				draw_wait(rx_pace, rx_left, rx_stall);
			end
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// checker: every accepted glyph word against the oldest prediction
	always @(posedge clk) begin : glyph_check
		glyph_word_t want;
		glyph_taken <= out_valid && out_ready;
		if (out_valid && out_ready) begin
			if (expected_glyphs.size() == 0) begin
				$error("glyph word 0x%0h arrived with none expected", glyph);
				mismatch_count++;
			end else begin
				want = expected_glyphs.pop_front();
				if (glyph !== want.code) begin
					$error("glyph: expected 0x%0h, actual 0x%0h", want.code, glyph);
					mismatch_count++;
				end
				if (end_of_row !== want.row_end) begin
					$error("end_of_row: expected %0b, actual %0b", want.row_end, end_of_row);
					mismatch_count++;
				end
				if (end_of_frame !== want.frame_end) begin
					$error("end_of_frame: expected %0b, actual %0b", want.frame_end,
						end_of_frame);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------ stimulus
	// Idle = every pixel taken and every predicted glyph received; with settle
	// the block also gets time to finish a last pixel that made no glyph.
	task automatic wait_idle(input bit settle);
		int spin;
		while (pixel_queue.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		spin = 0;
		while (expected_glyphs.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		if (expected_glyphs.size() != 0) begin
			$error("%0d glyph words never arrived", expected_glyphs.size());
			mismatch_count++;
			expected_glyphs.delete();
		end
		if (settle) begin
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  width_reg  = value[IMG_W_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = value[IMG_H_W-1:0];
			REG_WINDOW_SIZE:  window_reg = value[WIN_REG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pixel_queue.push_back('{r, g, b});
	endtask

	// One whole frame at the current settings. Tiles of gray give window
	// averages across the full glyph ramp; noise and saturated frames hit
	// every channel bit. Optionally the sender pauses halfway until drained.
	task automatic push_frame(input bit pause_mid, inout int pushed);
		int unsigned w, h, win, row, col;
		int          v;
		tone_t       tone;
		rgb_t        px;
		w    = clamp_to(32'(width_reg), 1, 1024);
		h    = clamp_to(32'(height_reg), 1, 2048);
		win  = clamp_to(32'(window_reg), 1, 16);
		tone = ($urandom_range(0, 3) >= 2) ? TONE_TILES : tone_t'($urandom_range(0, 1));
		for (row = 0; row < h; row++) begin
			if (pause_mid && row == h / 2 && row != 0) begin
				wait_idle(1'b0);
			end
			for (col = 0; col < w; col++) begin
				if (row % (2 * win) == 0 && col % win == 0) begin
					tile_shade[col / win] = $urandom_range(0, 255);
				end
				case (tone)
					TONE_NOISE: begin
						px.red   = 8'($urandom_range(0, 255));
						px.green = 8'($urandom_range(0, 255));
						px.blue  = 8'($urandom_range(0, 255));
					end
					TONE_SATURATED: begin
						px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					default: begin
						// equal channels give luma equal to the channel value
						v = tile_shade[col / win] + $urandom_range(0, 6) - 3;
						if (v < 0) v = 0;
						if (v > 255) v = 255;
						px.red   = 8'(v);
						px.green = 8'(v);
						px.blue  = 8'(v);
					end
				endcase
				pixel_queue.push_back(px);
				pushed++;
			end
		end
	endtask

	// registers written only with the block idle, then whole frames, then drain
	task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
		input logic [CFG_DATA_W-1:0] win, input bit pause_mid, input int frames,
		inout int pushed);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_WINDOW_SIZE, win);
		for (int f = 0; f < frames; f++) begin
			push_frame(pause_mid && f == 0, pushed);
		end
		wait_idle(1'b1);
	endtask

	initial begin : stimulus
		int          random_words;
		int          phase;
		int unsigned w, h, win;
		logic [CFG_DATA_W-1:0] w_data, win_data;
		random_words = 0;
		phase        = 0;
		@(posedge arst_n);
		repeat (3) @(posedge clk);

		// directed: 4x2, window 1 -> four glyphs from black, white, pure primaries and one mixed colour
		write_reg(REG_IMAGE_WIDTH, 12'd4);
		write_reg(REG_IMAGE_HEIGHT, 12'd2);
		write_reg(REG_WINDOW_SIZE, 12'd1);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd0, 8'd0);
		push_pixel(8'd0, 8'd255, 8'd0);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd0, 8'd0, 8'd255);
		push_pixel(8'd128, 8'd64, 8'd200);
		wait_idle(1'b1);

		// directed: 3x5, window 2 -> partial window column, odd last row stored only
		write_reg(REG_IMAGE_WIDTH, 12'd3);
		write_reg(REG_IMAGE_HEIGHT, 12'd5);
		write_reg(REG_WINDOW_SIZE, 12'd2);
		for (int i = 0; i < 15; i++) begin
			push_pixel(8'(i * 17), 8'(255 - i * 17), 8'(i * 53));
		end
		wait_idle(1'b1);

		// random small frames; stray upper bits on the narrower registers now and then
		while (random_words < RANDOM_WORDS) begin
			phase++;
			win = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(1, 8);
			w   = $urandom_range(1, 24);
			h   = $urandom_range(2, 24);
			if (phase == 1) begin
				// long receiver hold-off on a glyph-dense setting
				w       = 6;
				h       = 12;
				win     = 1;
				hold_go = 1'b1;
			end
			w_data   = CFG_DATA_W'(w);
			win_data = CFG_DATA_W'(win);
			if ($urandom_range(0, 3) == 0) begin
				w_data[CFG_DATA_W-1]             = 1'b1;
				win_data[CFG_DATA_W-1:WIN_REG_W] = 7'($urandom_range(0, 127));
			end
			run_phase(w_data, CFG_DATA_W'(h), win_data, phase % 7 == 4, $urandom_range(1, 2),
				random_words);
		end

		// register extremes, including values held by the clamp
		run_phase(12'd1, 12'd6, 12'd0, 1'b0, 1, random_words);       // one column, window 0
		run_phase(12'd7, 12'd1, 12'd1, 1'b0, 2, random_words);       // one row: no glyphs
		run_phase(12'd5, 12'd0, 12'd3, 1'b0, 2, random_words);       // height 0
		run_phase(12'd17, 12'd33, 12'd31, 1'b0, 1, random_words);    // window past max, partials
		run_phase(12'd0, 12'd4, 12'd1, 1'b0, 2, random_words);       // width 0

		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
